[rtl/combined_lcg_shuffle_rng_top_assert.svh]
// Assertion macros for the combined generator block.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message string.
`ifndef COMBINED_LCG_SHUFFLE_RNG_TOP_ASSERT_SVH
`define COMBINED_LCG_SHUFFLE_RNG_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define CLSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CLSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CLSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define CLSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/clsr_pkg.sv]
`timescale 1ns / 1ps

package clsr_pkg;

    localparam int TABLE_SIZE = 32;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int VAL_W      = 31;
    localparam int SEED_W     = 32;
    localparam int MUL_W      = 16;
    localparam int FOLD_W     = 8;
    localparam int FILL_STEPS = TABLE_SIZE + 8;
    localparam int CNT_W      = $clog2(FILL_STEPS);

    localparam logic [VAL_W-1:0]  GEN1_MOD  = 31'd2147483563;
    localparam logic [MUL_W-1:0]  GEN1_MUL  = 16'd40014;
    localparam logic [FOLD_W-1:0] GEN1_FOLD = 8'd85;
    localparam logic [VAL_W-1:0]  GEN2_MOD  = 31'd2147483399;
    localparam logic [MUL_W-1:0]  GEN2_MUL  = 16'd40692;
    localparam logic [FOLD_W-1:0] GEN2_FOLD = 8'd249;

    localparam logic [VAL_W-1:0]  OUT_RANGE    = 31'd2147483562;
    localparam logic [VAL_W-1:0]  SECOND_RESET = 31'd123456789;
    localparam logic [SEED_W-1:0] SEED_RESET   = 32'hFFFF_FFFF;

    localparam longint SLOT_DIV_L = 64'd1 + 64'd2147483562 / TABLE_SIZE;
    localparam logic [SEED_W-1:0] SLOT_DIV = SEED_W'(SLOT_DIV_L);

    typedef enum logic
    {
        GEN_FIRST,
        GEN_SECOND
    } gen_sel_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_FMUL,
        S_FFOLD,
        S_MUL,
        S_FOLD,
        S_OUT
    } state_t;

    typedef struct packed
    {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [VAL_W-1:0]  wr_data;
    } table_req_t;

endpackage

[rtl/clsr_mulmod.sv]
`timescale 1ns / 1ps

module clsr_mulmod
(
    input  logic                         clk,
    input  clsr_pkg::gen_sel_t           gen_sel,
    input  logic                         load,
    input  logic [clsr_pkg::VAL_W-1:0]   x,
    output logic [clsr_pkg::VAL_W-1:0]   result
);
    import clsr_pkg::*;

    localparam int PROD_W = VAL_W + MUL_W;

    logic [MUL_W-1:0]  mul;
    logic [VAL_W-1:0]  modulus;
    logic [FOLD_W-1:0] fold_k;
    logic [PROD_W-1:0] prod_reg;
    logic [MUL_W-1:0]  prod_hi;
    logic [VAL_W:0]    fold_sum;
    logic [VAL_W:0]    fold_red;

    always_comb
    begin
        unique case (gen_sel)
            GEN_FIRST:
            begin
                mul     = GEN1_MUL;
                modulus = GEN1_MOD;
                fold_k  = GEN1_FOLD;
            end
            GEN_SECOND:
            begin
                mul     = GEN2_MUL;
                modulus = GEN2_MOD;
                fold_k  = GEN2_FOLD;
            end
            default:
            begin
                mul     = GEN1_MUL;
                modulus = GEN1_MOD;
                fold_k  = GEN1_FOLD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= PROD_W'(x) * PROD_W'(mul);
        end
    end

    // The word size is the modulus plus a small constant, so the high part
    // folds back in with one small multiply and a single conditional subtract.
    assign prod_hi  = prod_reg[PROD_W-1:VAL_W];
    assign fold_sum = (VAL_W+1)'(prod_hi) * (VAL_W+1)'(fold_k)
                    + {1'b0, prod_reg[VAL_W-1:0]};
    assign fold_red = (fold_sum >= {1'b0, modulus}) ? fold_sum - {1'b0, modulus} : fold_sum;
    assign result   = fold_red[VAL_W-1:0];

endmodule

[rtl/clsr_table.sv]
`timescale 1ns / 1ps

module clsr_table
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  clsr_pkg::table_req_t         req,
    output logic [clsr_pkg::VAL_W-1:0]   rd_data
);
    import clsr_pkg::*;

    logic [VAL_W-1:0]      mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] valid_reg;
    logic [VAL_W-1:0]      rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // An entry never written reads as zero, the table's reset contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[rtl/combined_lcg_shuffle_rng_top.sv]
`timescale 1ns / 1ps

// Channel   Handshake                  Word
// draw      draw_valid / draw_stall    reload_seed
// result    result_valid / result_stall random_value
// seed      seed_valid / seed_ready    seed_value
//
// A draw runs through accept, multiply, modular fold and table write-back.
// A draw that finds the first generator zero or negative first runs the table
// fill, 40 steps of multiply and fold through the first generator's unit.
// Reset clears the table at once through per-entry valid bits. A result
// waiting under result_stall holds the write-back cycle.

`include "combined_lcg_shuffle_rng_top_assert.svh"

module combined_lcg_shuffle_rng_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              draw_valid,
    output logic                              draw_stall,
    input  logic                              reload_seed,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [clsr_pkg::VAL_W-1:0]        random_value,
    input  logic                              seed_valid,
    output logic                              seed_ready,
    input  logic signed [clsr_pkg::SEED_W-1:0] seed_value
);
    import clsr_pkg::*;

    localparam int SHIFT = VAL_W - SLOT_W;

    state_t            state_reg, state_next;
    logic [SEED_W-1:0] seed_reg;
    logic [SEED_W-1:0] g1_reg, g1_next;
    logic [VAL_W-1:0]  g2_reg, g2_next;
    logic [VAL_W-1:0]  last_reg, last_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              res_valid_reg, res_valid_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;

    logic              m1_load, m2_load;
    logic [VAL_W-1:0]  m1_result, m2_result;
    table_req_t        tbl_req;
    logic [VAL_W-1:0]  tbl_data;

    logic [SEED_W-1:0] g1_eff;
    logic              g1_nonpos;
    logic [SEED_W-1:0] g1_fixed;

    logic [SLOT_W:0]   slot_est, slot_inc, slot_full;
    logic [VAL_W+1:0]  slot_bound;
    logic [SLOT_W-1:0] slot;

    logic [VAL_W+1:0]  diff, diff_adj;
    logic [VAL_W-1:0]  y;
    logic              out_blocked;

    clsr_mulmod u_gen1
    (
        .clk     (clk),
        .gen_sel (GEN_FIRST),
        .load    (m1_load),
        .x       (g1_reg[VAL_W-1:0]),
        .result  (m1_result)
    );

    clsr_mulmod u_gen2
    (
        .clk     (clk),
        .gen_sel (GEN_SECOND),
        .load    (m2_load),
        .x       (g2_reg),
        .result  (m2_result)
    );

    clsr_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (tbl_data)
    );

    assign draw_stall   = (state_reg != S_IDLE);
    assign seed_ready   = 1'b1;
    assign result_valid = res_valid_reg;
    assign random_value = res_value_reg;

    assign g1_eff    = reload_seed ? seed_reg : g1_reg;
    assign g1_nonpos = g1_eff[SEED_W-1] || (g1_eff == '0);
    always_comb
    begin
        if (g1_eff == '0)
        begin
            g1_fixed = SEED_W'(1);
        end
        else if (g1_eff == {1'b1, {(SEED_W-1){1'b0}}})
        begin
            g1_fixed = {1'b0, {(SEED_W-1){1'b1}}};
        end
        else
        begin
            g1_fixed = (~g1_eff) + 1'b1;
        end
    end

    // The slot width is close to a power of two, so the top bits give the
    // quotient up to a correction of one.
    assign slot_est   = {1'b0, last_reg[VAL_W-1:SHIFT]};
    assign slot_inc   = slot_est + 1'b1;
    assign slot_bound = (VAL_W+2)'(slot_inc) * (VAL_W+2)'(SLOT_DIV);
    assign slot_full  = ({2'b00, last_reg} >= slot_bound) ? slot_inc : slot_est;
    assign slot       = (slot_full >= (SLOT_W+1)'(TABLE_SIZE)) ? SLOT_W'(TABLE_SIZE - 1)
                                                               : slot_full[SLOT_W-1:0];

    assign diff     = {2'b00, tbl_data} - {2'b00, g2_reg};
    assign diff_adj = (diff[VAL_W+1] || (diff == '0)) ? diff + {2'b00, OUT_RANGE} : diff;
    assign y        = diff_adj[VAL_W-1:0];

    assign out_blocked = res_valid_reg && result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= SEED_RESET;
            g1_reg        <= SEED_RESET;
            g2_reg        <= SECOND_RESET;
            last_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            g1_reg        <= g1_next;
            g2_reg        <= g2_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            if (seed_valid && seed_ready)
            begin
                seed_reg <= seed_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        res_value_reg <= res_value_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        g1_next        = g1_reg;
        g2_next        = g2_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        res_valid_next = out_blocked;
        res_value_next = res_value_reg;
        m1_load        = 1'b0;
        m2_load        = 1'b0;
        tbl_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (draw_valid)
                begin
                    if (g1_nonpos)
                    begin
                        g1_next    = g1_fixed;
                        g2_next    = g1_fixed[VAL_W-1:0];
                        cnt_next   = CNT_W'(FILL_STEPS - 1);
                        state_next = S_FMUL;
                    end
                    else
                    begin
                        g1_next    = g1_eff;
                        state_next = S_MUL;
                    end
                end
            end
            S_FMUL:
            begin
                m1_load    = 1'b1;
                state_next = S_FFOLD;
            end
            S_FFOLD:
            begin
                g1_next = {1'b0, m1_result};
                if (cnt_reg < CNT_W'(TABLE_SIZE))
                begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = cnt_reg[SLOT_W-1:0];
                    tbl_req.wr_data = m1_result;
                end
                if (cnt_reg == '0)
                begin
                    last_next  = m1_result;
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_FMUL;
                end
            end
            S_MUL:
            begin
                m1_load         = 1'b1;
                m2_load         = 1'b1;
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = slot;
                slot_next       = slot;
                state_next      = S_FOLD;
            end
            S_FOLD:
            begin
                g1_next    = {1'b0, m1_result};
                g2_next    = m2_result;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_blocked)
                begin
                    tbl_req.wr_en   = 1'b1;
                    tbl_req.wr_addr = slot_reg;
                    tbl_req.wr_data = g1_reg[VAL_W-1:0];
                    last_next       = y;
                    res_value_next  = y;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `CLSR_ASSERT_NEXT(a_accept_starts, clk, rst_n, draw_valid && !draw_stall, (state_reg == S_FMUL || state_reg == S_MUL), "accepted draw did not start")
    `CLSR_ASSERT_IMP(a_g1_not_negative, clk, rst_n, state_reg == S_MUL, !g1_reg[SEED_W-1], "first generator negative at draw")
    `CLSR_ASSERT_IMP(a_result_range, clk, rst_n, res_valid_reg, (res_value_reg != '0 && res_value_reg <= OUT_RANGE), "result word out of range")
    `CLSR_ASSERT_NEXT(a_out_delivers, clk, rst_n, state_reg == S_OUT && !out_blocked, res_valid_reg, "finished draw left no result")
    `CLSR_ASSERT_IMP(a_fill_count, clk, rst_n, (state_reg == S_FMUL || state_reg == S_FFOLD), cnt_reg < CNT_W'(FILL_STEPS), "fill counter out of range")

endmodule
